// ----- hw/rtl/tpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pkg: shared constants and helpers for the triangle plane quadric block
// Word count, index codes and the quadric index-to-plane-pair map.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int NUM_PLANE = 4;
	localparam int NUM_COEFF = 14;

	localparam logic [3:0] IDX_FIRST_QUAD = 4'd4;
	localparam logic [3:0] IDX_LAST       = 4'd13;

	// plane component pair {i, j} for a quadric word index (upper triangle, row order)
	function automatic logic [3:0] quad_pair(input logic [3:0] idx);
		logic [3:0] r;
		case (idx)
			4'd4:    r = {2'd0, 2'd0};
			4'd5:    r = {2'd0, 2'd1};
			4'd6:    r = {2'd0, 2'd2};
			4'd7:    r = {2'd0, 2'd3};
			4'd8:    r = {2'd1, 2'd1};
			4'd9:    r = {2'd1, 2'd2};
			4'd10:   r = {2'd1, 2'd3};
			4'd11:   r = {2'd2, 2'd2};
			4'd12:   r = {2'd2, 2'd3};
			4'd13:   r = {2'd3, 2'd3};
			default: r = {2'd0, 2'd0};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/triangle_plane_quadric.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted triangle passes the front end, square root, dividers and serializer to
// its first coefficient word; then the fourteen words follow one per cycle when the
// output is not stalled. The single output word port bounds the triangle rate. The
// square root and the three dividers work on later triangles while earlier ones
// drain. arst_n clears all valid bits at once.
// ----------------------------------------------------------------------------
// triangle_plane_quadric: unit plane and error quadric of one triangle
// Cross product, normalize (isqrt + divide), plane offset, then a word serializer
// that emits the four plane words and forms the ten quadric terms with a split multiplier.
// ----------------------------------------------------------------------------
module triangle_plane_quadric (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                tri_valid,
	output logic               tri_stall,
	input  wire  signed [31:0] corner_a_x,
	input  wire  signed [31:0] corner_a_y,
	input  wire  signed [31:0] corner_a_z,
	input  wire  signed [31:0] corner_b_x,
	input  wire  signed [31:0] corner_b_y,
	input  wire  signed [31:0] corner_b_z,
	input  wire  signed [31:0] corner_c_x,
	input  wire  signed [31:0] corner_c_y,
	input  wire  signed [31:0] corner_c_z,
	output logic               coeff_valid,
	input  wire                coeff_stall,
	output logic        [3:0]  coeff_index,
	output logic signed [63:0] coeff_value,
	output logic               degenerate,
	output logic               last_coeff
);

	// ---------------- stage registers ----------------
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [31:0] a_s1[3], b_s1[3], c_s1[3];
	logic signed [32:0] e1_s2[3], e2_s2[3];
	logic signed [31:0] a_s2[3], a_s3[3], a_s4[3], a_s5[3], a_s6[3], a_s7[3], a_s8[3];
	logic signed [65:0] pr_s3[6];
	logic signed [66:0] n_s4[3];
	logic        [30:0] m_s5[3], m_s6[3], m_s7[3];
	logic               ng_s5[3], ng_s6[3], ng_s7[3], ng_s8[3];
	logic               dg_s5, dg_s6, dg_s7, dg_s8, dg_s9, dg_s10;
	logic        [61:0] sqr_s6[3];

	// square root unit, 4 result bits per cycle
	logic        [63:0] sq_s_s7;
	logic        [34:0] sq_rem_s7;
	logic        [31:0] sq_res_s7;
	logic        [2:0]  sq_cnt_s7;
	logic               sq_done_s7;

	// three dividers sharing the length, 3 quotient bits per cycle
	logic        [31:0] dv_len_s8;
	logic        [31:0] dv_rem_s8[3];
	logic        [32:0] dv_q_s8[3];
	logic        [32:0] dv_bits_s8[3];
	logic        [3:0]  dv_cnt_s8;
	logic               dv_done_s8;

	logic        [32:0] pm_s9[3];
	logic               pn_s9[3];
	logic signed [65:0] dp_s9[3];

	logic               pl_neg_s10[4];
	logic        [48:0] pl_mag_s10[4];

	// serializer
	logic               ser_v_q;
	logic        [3:0]  ser_k_q;
	logic               ser_neg_q[4];
	logic        [48:0] ser_mag_q[4];
	logic               ser_dg_q;

	// product stage of the word path
	logic               v_s11;
	logic        [3:0]  idx_s11;
	logic               quad_s11, neg_s11, dg_s11, last_s11;
	logic        [48:0] mag_s11;
	logic        [47:0] pp_hh_s11;
	logic        [48:0] pp_hl_s11, pp_lh_s11;
	logic        [49:0] pp_ll_s11;

	// ---------------- flow control ----------------
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdy10, rdy_ser;
	logic en_o, issue;

	assign en_o    = !coeff_valid || !coeff_stall;
	assign issue   = ser_v_q && en_o;
	assign rdy_ser = !ser_v_q || (issue && ser_k_q == tpq_pkg::IDX_LAST);
	assign rdy10   = !v_s10 || rdy_ser;
	assign rdy9    = !v_s9 || rdy10;
	assign rdy8    = !v_s8 || (dv_done_s8 && rdy9);
	assign rdy7    = !v_s7 || (sq_done_s7 && rdy8);
	assign rdy6    = !v_s6 || rdy7;
	assign rdy5    = !v_s5 || rdy6;
	assign rdy4    = !v_s4 || rdy5;
	assign rdy3    = !v_s3 || rdy4;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign tri_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			sq_done_s7 <= 1'b0;
			sq_cnt_s7 <= 3'd0;
			dv_done_s8 <= 1'b0;
			dv_cnt_s8 <= 4'd0;
			ser_v_q <= 1'b0;
			ser_k_q <= 4'd0;
			v_s11 <= 1'b0;
			coeff_valid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= tri_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) begin
				v_s7 <= v_s6;
				sq_done_s7 <= 1'b0;
				sq_cnt_s7 <= 3'd0;
			end else if (v_s7 && !sq_done_s7) begin
				sq_cnt_s7 <= sq_cnt_s7 + 3'd1;
				if (sq_cnt_s7 == 3'd7) sq_done_s7 <= 1'b1;
			end
			if (rdy8) begin
				v_s8 <= v_s7 && sq_done_s7;
				dv_done_s8 <= 1'b0;
				dv_cnt_s8 <= 4'd0;
			end else if (v_s8 && !dv_done_s8) begin
				dv_cnt_s8 <= dv_cnt_s8 + 4'd1;
				if (dv_cnt_s8 == 4'd10) dv_done_s8 <= 1'b1;
			end
			if (rdy9) v_s9 <= v_s8 && dv_done_s8;
			if (rdy10) v_s10 <= v_s9;
			if (rdy_ser) begin
				ser_v_q <= v_s10;
				ser_k_q <= 4'd0;
			end else if (issue) begin
				ser_k_q <= ser_k_q + 4'd1;
			end
			if (en_o) begin
				v_s11 <= issue;
				coeff_valid <= v_s11;
			end
		end
	end

	// ---------------- front end: edges, cross product ----------------
	always_ff @(posedge clk) begin
		if (rdy1) begin
			a_s1[0] <= corner_a_x; a_s1[1] <= corner_a_y; a_s1[2] <= corner_a_z;
			b_s1[0] <= corner_b_x; b_s1[1] <= corner_b_y; b_s1[2] <= corner_b_z;
			c_s1[0] <= corner_c_x; c_s1[1] <= corner_c_y; c_s1[2] <= corner_c_z;
		end
		if (rdy2) begin
			for (int i = 0; i < 3; i++) begin
				e1_s2[i] <= 33'(b_s1[i]) - 33'(a_s1[i]);
				e2_s2[i] <= 33'(c_s1[i]) - 33'(a_s1[i]);
				a_s2[i]  <= a_s1[i];
			end
		end
		if (rdy3) begin
			pr_s3[0] <= e1_s2[1] * e2_s2[2];
			pr_s3[1] <= e2_s2[1] * e1_s2[2];
			pr_s3[2] <= e1_s2[2] * e2_s2[0];
			pr_s3[3] <= e2_s2[2] * e1_s2[0];
			pr_s3[4] <= e1_s2[0] * e2_s2[1];
			pr_s3[5] <= e2_s2[0] * e1_s2[1];
			for (int i = 0; i < 3; i++) a_s3[i] <= a_s2[i];
		end
		if (rdy4) begin
			for (int i = 0; i < 3; i++) begin
				n_s4[i] <= 67'(pr_s3[2*i]) - 67'(pr_s3[2*i+1]);
				a_s4[i] <= a_s3[i];
			end
		end
	end

	// ---------------- normalize the largest component to [2^30, 2^31) ----------------
	logic [66:0] nmag[3];
	logic [66:0] nor_all;
	logic [66:0] nsh[3];
	logic [6:0]  nbl;

	always_comb begin
		nor_all = '0;
		for (int i = 0; i < 3; i++) begin
			nmag[i] = n_s4[i][66] ? 67'(-n_s4[i]) : 67'(n_s4[i]);
			nor_all = nor_all | nmag[i];
		end
		nbl = 7'd0;
		for (int b = 0; b < 67; b++) begin
			if (nor_all[b]) nbl = 7'(b + 1);
		end
		for (int i = 0; i < 3; i++) begin
			if (nbl > 7'd31) nsh[i] = nmag[i] >> (nbl - 7'd31);
			else             nsh[i] = nmag[i] << (7'd31 - nbl);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			for (int i = 0; i < 3; i++) begin
				m_s5[i]  <= nsh[i][30:0];
				ng_s5[i] <= n_s4[i][66];
				a_s5[i]  <= a_s4[i];
			end
			dg_s5 <= (nbl == 7'd0);
		end
		if (rdy6) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s6[i] <= m_s5[i] * m_s5[i];
				m_s6[i]   <= m_s5[i];
				ng_s6[i]  <= ng_s5[i];
				a_s6[i]   <= a_s5[i];
			end
			dg_s6 <= dg_s5;
		end
	end

	// ---------------- integer square root ----------------
	logic [34:0] sq_rem_nx;
	logic [31:0] sq_res_nx;
	logic [34:0] sq_trial;

	always_comb begin
		sq_rem_nx = sq_rem_s7;
		sq_res_nx = sq_res_s7;
		sq_trial  = '0;
		for (int i = 0; i < 4; i++) begin
			sq_rem_nx = {sq_rem_nx[32:0], sq_s_s7[63-2*i -: 2]};
			sq_trial  = {1'b0, sq_res_nx, 2'b01};
			if (sq_rem_nx >= sq_trial) begin
				sq_rem_nx = sq_rem_nx - sq_trial;
				sq_res_nx = {sq_res_nx[30:0], 1'b1};
			end else begin
				sq_res_nx = {sq_res_nx[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy7) begin
			sq_s_s7   <= 64'(sqr_s6[0]) + 64'(sqr_s6[1]) + 64'(sqr_s6[2]);
			sq_rem_s7 <= '0;
			sq_res_s7 <= '0;
			for (int i = 0; i < 3; i++) begin
				m_s7[i]  <= m_s6[i];
				ng_s7[i] <= ng_s6[i];
				a_s7[i]  <= a_s6[i];
			end
			dg_s7 <= dg_s6;
		end else if (v_s7 && !sq_done_s7) begin
			sq_s_s7   <= {sq_s_s7[55:0], 8'd0};
			sq_rem_s7 <= sq_rem_nx;
			sq_res_s7 <= sq_res_nx;
		end
	end

	// ---------------- dividers: (m << 32) / len ----------------
	logic [31:0] dv_rem_nx[3];
	logic [32:0] dv_q_nx[3];
	logic [32:0] dv_t;

	always_comb begin
		dv_t = '0;
		for (int u = 0; u < 3; u++) begin
			dv_rem_nx[u] = dv_rem_s8[u];
			dv_q_nx[u]   = dv_q_s8[u];
			for (int b = 0; b < 3; b++) begin
				dv_t = {dv_rem_nx[u], dv_bits_s8[u][32-b]};
				if (dv_t >= {1'b0, dv_len_s8}) begin
					dv_rem_nx[u] = 32'(dv_t - {1'b0, dv_len_s8});
					dv_q_nx[u]   = {dv_q_nx[u][31:0], 1'b1};
				end else begin
					dv_rem_nx[u] = dv_t[31:0];
					dv_q_nx[u]   = {dv_q_nx[u][31:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy8) begin
			dv_len_s8 <= sq_res_s7;
			for (int u = 0; u < 3; u++) begin
				dv_rem_s8[u]  <= {2'b00, m_s7[u][30:1]};
				dv_bits_s8[u] <= {m_s7[u][0], 32'd0};
				dv_q_s8[u]    <= '0;
				ng_s8[u]      <= ng_s7[u];
				a_s8[u]       <= a_s7[u];
			end
			dg_s8 <= dg_s7;
		end else if (v_s8 && !dv_done_s8) begin
			for (int u = 0; u < 3; u++) begin
				dv_rem_s8[u]  <= dv_rem_nx[u];
				dv_q_s8[u]    <= dv_q_nx[u];
				dv_bits_s8[u] <= {dv_bits_s8[u][29:0], 3'd0};
			end
		end
	end

	// ---------------- plane offset d = -(n . A) ----------------
	logic signed [33:0] p_sgn[3];
	logic signed [67:0] dsum;
	logic        [67:0] dmag;
	logic        [48:0] p3_mag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_sgn[i] = pn_s9[i] ? -$signed({1'b0, pm_s9[i]}) : $signed({1'b0, pm_s9[i]});
		end
		dsum   = 68'(dp_s9[0]) + 68'(dp_s9[1]) + 68'(dp_s9[2]);
		dmag   = dsum[67] ? 68'(-dsum) : 68'(dsum);
		p3_mag = dmag[64:16];
	end

	logic signed [33:0] p_sgn8[3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_sgn8[i] = (ng_s8[i] && dv_q_s8[i] != '0) ? -$signed({1'b0, dv_q_s8[i]})
			                                          : $signed({1'b0, dv_q_s8[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (rdy9) begin
			for (int i = 0; i < 3; i++) begin
				pm_s9[i] <= dv_q_s8[i];
				pn_s9[i] <= ng_s8[i] && dv_q_s8[i] != '0;
				dp_s9[i] <= p_sgn8[i] * a_s8[i];
			end
			dg_s9 <= dg_s8;
		end
		if (rdy10) begin
			for (int i = 0; i < 3; i++) begin
				pl_mag_s10[i] <= dg_s9 ? '0 : {16'd0, pm_s9[i]};
				pl_neg_s10[i] <= !dg_s9 && pn_s9[i] && p_sgn[i] != '0;
			end
			pl_mag_s10[3] <= dg_s9 ? '0 : p3_mag;
			pl_neg_s10[3] <= !dg_s9 && !dsum[67] && p3_mag != '0;
			dg_s10 <= dg_s9;
		end
		if (rdy_ser) begin
			for (int i = 0; i < 4; i++) begin
				ser_mag_q[i] <= pl_mag_s10[i];
				ser_neg_q[i] <= pl_neg_s10[i];
			end
			ser_dg_q <= dg_s10;
		end
	end

	// ---------------- word path: partial products, then sum and saturate ----------------
	logic [3:0]  pair;
	logic [48:0] qx, qy;

	always_comb begin
		pair = tpq_pkg::quad_pair(ser_k_q);
		qx   = ser_mag_q[pair[3:2]];
		qy   = ser_mag_q[pair[1:0]];
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			idx_s11   <= ser_k_q;
			quad_s11  <= ser_k_q >= tpq_pkg::IDX_FIRST_QUAD;
			last_s11  <= ser_k_q == tpq_pkg::IDX_LAST;
			dg_s11    <= ser_dg_q;
			mag_s11   <= ser_mag_q[ser_k_q[1:0]];
			neg_s11   <= (ser_k_q >= tpq_pkg::IDX_FIRST_QUAD)
			             ? (ser_neg_q[pair[3:2]] ^ ser_neg_q[pair[1:0]])
			             : ser_neg_q[ser_k_q[1:0]];
			pp_hh_s11 <= qx[48:25] * qy[48:25];
			pp_hl_s11 <= qx[48:25] * qy[24:0];
			pp_lh_s11 <= qx[24:0] * qy[48:25];
			pp_ll_s11 <= qx[24:0] * qy[24:0];
		end
	end

	logic [97:0] qsum;
	logic [65:0] qm;
	logic [63:0] word_val;

	always_comb begin
		qsum = {pp_hh_s11, 50'd0} + 98'({pp_hl_s11, 25'd0}) + 98'({pp_lh_s11, 25'd0})
		       + 98'(pp_ll_s11);
		qm   = qsum[97:32];
		if (!quad_s11) begin
			word_val = neg_s11 ? -{15'd0, mag_s11} : {15'd0, mag_s11};
		end else if (!neg_s11) begin
			word_val = (qm[65:63] != 3'd0) ? 64'h7FFF_FFFF_FFFF_FFFF : qm[63:0];
		end else if (qm[65:64] != 2'd0 || (qm[63] && qm[62:0] != '0)) begin
			word_val = 64'h8000_0000_0000_0000;
		end else begin
			word_val = -qm[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			coeff_index <= idx_s11;
			coeff_value <= word_val;
			degenerate  <= dg_s11;
			last_coeff  <= last_s11;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tpq_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_check: port-level checks for triangle_plane_quadric
// Output word hold, index range, last marker and degenerate zeroing.
// ----------------------------------------------------------------------------
module tpq_check (
	input wire               clk,
	input wire               arst_n,
	input wire               tri_valid,
	input wire               tri_stall,
	input wire               coeff_valid,
	input wire               coeff_stall,
	input wire        [3:0]  coeff_index,
	input wire signed [63:0] coeff_value,
	input wire               degenerate,
	input wire               last_coeff
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coeff_valid && coeff_stall |=> coeff_valid && $stable(coeff_index)
			&& $stable(coeff_value) && $stable(last_coeff))
		else $error("stalled output word changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		coeff_valid |-> coeff_index <= tpq_pkg::IDX_LAST)
		else $error("coefficient index out of range");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		coeff_valid |-> (last_coeff == (coeff_index == tpq_pkg::IDX_LAST)))
		else $error("last marker does not match index");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		coeff_valid && degenerate |-> coeff_value == 64'sd0)
		else $error("degenerate triangle with nonzero coefficient");

endmodule

bind triangle_plane_quadric tpq_check u_tpq_check (.*);
`default_nettype wire
